/* sv/aolih_pkg.sv */
// ----------------------------------------------------------------------------
// aolih_pkg
// Shared payload types and command and status codes of the open-list heap.
// ----------------------------------------------------------------------------
package aolih_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [2:0] ST_APPENDED  = 3'd0;
    localparam logic [2:0] ST_DROPPED   = 3'd1;
    localparam logic [2:0] ST_DECREASED = 3'd2;
    localparam logic [2:0] ST_POPPED    = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [15:0] cost_so_far;
        logic [16:0] cost_estimate;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        heap_full;
        logic [7:0]  out_x;
        logic [7:0]  out_y;
        logic [15:0] out_cost_so_far;
        logic [16:0] out_cost_estimate;
        logic        is_empty;
    } out_item_t;

endpackage

/* sv/astar_open_list_indexed_heap.sv */
// ----------------------------------------------------------------------------
// astar_open_list_indexed_heap
// Open list of a grid path search: indexed binary min-heap on f = g + h.
// ----------------------------------------------------------------------------
// One command is handled at a time. A drop or a full refusal goes from
// S_LOOK to S_DONE, and a pop on an empty heap from idle to S_DONE. An
// insert passes S_UPRD and S_UPCMP for each heap level that the entry
// climbs, since every level writes the moving entry and its cell position
// and reads the parent over the heap memory port. A pop, or a key change
// that pushes an entry down, passes S_POSW, S_DNRD, S_DNR2, S_DNSEL and
// S_DNCMP per level, reading both children, choosing one and writing back
// the exchanged pair and their cell positions.
// After reset and after each clear command the cell tables are swept, one
// cell per cycle over all 2**(X_BITS+Y_BITS) cells; no command is accepted.
// The result sits in an output register, and a new command is taken only
// once that register is free or is emptied by a transfer in the same cycle.
module astar_open_list_indexed_heap #(
    parameter int X_BITS     = 8,
    parameter int Y_BITS     = 8,
    parameter int HEAP_DEPTH = 1024,
    parameter int COST_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  aolih_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output aolih_pkg::out_item_t  m_data
);

    localparam int CB = X_BITS + Y_BITS;
    localparam int CELLS = 1 << CB;
    localparam int SB = $clog2(HEAP_DEPTH + 1);
    localparam int KB = 18 > COST_BITS + 1 ? 18 : COST_BITS + 1;
    localparam int BB = COST_BITS + 1;

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_LOOK = 4'd2,
        S_DEC = 4'd3, S_UPRD = 4'd4, S_UPCMP = 4'd5, S_POP1 = 4'd6,
        S_POP2 = 4'd7, S_DNRD = 4'd8, S_DNR2 = 4'd9, S_DNCMP = 4'd10,
        S_DNSEL = 4'd11, S_DONE = 4'd12, S_POSW = 4'd13;

    typedef struct packed {
        logic [X_BITS-1:0]    x;
        logic [Y_BITS-1:0]    y;
        logic [COST_BITS-1:0] g;
        logic [16:0]          h;
    } ent_t;

    // Memories: heap entries, cell positions, cell best costs.
    ent_t            heap_mem [1:HEAP_DEPTH];
    logic [SB-1:0]   slot_mem [CELLS];
    logic [BB-1:0]   best_mem [CELLS];

    logic          hw_en;  logic [SB-1:0] hw_a;  ent_t hw_d;
    logic [SB-1:0] hr_a;   ent_t hr_q;
    logic          sw_en;  logic [CB-1:0] sw_a;  logic [SB-1:0] sw_d;
    logic          bw_en;  logic [CB-1:0] bw_a;  logic [BB-1:0] bw_d;
    logic [CB-1:0] tr_a;   logic [SB-1:0] sr_q;  logic [BB-1:0] br_q;

    always_ff @(posedge aclk) begin
        if (hw_en) begin
            heap_mem[hw_a] <= hw_d;
        end
        hr_q <= heap_mem[hr_a];
        if (sw_en) begin
            slot_mem[sw_a] <= sw_d;
        end
        if (bw_en) begin
            best_mem[bw_a] <= bw_d;
        end
        sr_q <= slot_mem[tr_a];
        br_q <= best_mem[tr_a];
    end

    logic [3:0]     state_reg, state_next;
    logic [CB:0]    clr_reg, clr_next;
    logic [SB-1:0]  cnt_reg, cnt_next;
    logic [SB-1:0]  pos_reg, pos_next;      // slot of the moving entry
    logic [SB-1:0]  oth_reg, oth_next;      // parent or chosen child slot
    ent_t           cur_reg, cur_next;      // moving entry
    ent_t           lft_reg, lft_next;      // other entry / left child
    logic           dn_reg, dn_next;        // decrease also sifts down
    aolih_pkg::in_item_t  cmd_reg, cmd_next;
    logic                 ov_reg, ov_next;
    aolih_pkg::out_item_t od_reg, od_next;

    function automatic logic [KB-1:0] key_of(ent_t e);
        return KB'(e.g) + KB'(e.h);
    endfunction

    logic [CB-1:0] in_cell;
    assign in_cell = {Y_BITS'(cmd_reg.cell_y), X_BITS'(cmd_reg.cell_x)};
    logic [CB-1:0] acc_cell;
    assign acc_cell = {Y_BITS'(s_data.cell_y), X_BITS'(s_data.cell_x)};
    logic [COST_BITS-1:0] in_g;
    assign in_g = COST_BITS'(cmd_reg.cost_so_far);

    assign s_ready = (state_reg == S_IDLE) && (!ov_reg || m_ready);
    assign m_valid = ov_reg;
    assign m_data  = od_reg;

    always_comb begin
        state_next = state_reg; clr_next = clr_reg; cnt_next = cnt_reg;
        pos_next = pos_reg; oth_next = oth_reg; cur_next = cur_reg;
        lft_next = lft_reg; dn_next = dn_reg; cmd_next = cmd_reg;
        ov_next = ov_reg && !m_ready; od_next = od_reg;
        hw_en = 1'b0; hw_a = pos_reg; hw_d = cur_reg; hr_a = pos_reg;
        sw_en = 1'b0; sw_a = in_cell; sw_d = '0;
        bw_en = 1'b0; bw_a = in_cell; bw_d = '0; tr_a = in_cell;
        case (state_reg)
            S_CLR: begin
                sw_en = 1'b1; bw_en = 1'b1; sw_a = clr_reg[CB-1:0];
                bw_a = clr_reg[CB-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (CB+1)'(CELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                // The cell tables are read for the offered cell, so the
                // lookup is ready in the cycle after the transfer.
                tr_a = acc_cell;
                if (s_valid && s_ready) begin
                    cmd_next = s_data;
                    od_next = '0;
                    case (s_data.command)
                        aolih_pkg::CMD_INSERT: state_next = S_LOOK;
                        aolih_pkg::CMD_POP: begin
                            if (cnt_reg == '0) begin
                                od_next.status = aolih_pkg::ST_EMPTY;
                                state_next = S_DONE;
                            end else begin
                                hr_a = SB'(1);
                                state_next = S_POP1;
                            end
                        end
                        aolih_pkg::CMD_CLEAR: begin
                            cnt_next = '0; clr_next = '0;
                            od_next.status = aolih_pkg::ST_CLEARED;
                            od_next.is_empty = 1'b1;
                            ov_next = 1'b1;
                            state_next = S_CLR;
                        end
                        default: begin
                            od_next.status = aolih_pkg::ST_DROPPED;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                // tables read was issued in the accepting cycle (tr_a = cell)
                cur_next = '{x: X_BITS'(cmd_reg.cell_x),
                             y: Y_BITS'(cmd_reg.cell_y), g: in_g,
                             h: cmd_reg.cost_estimate};
                if (br_q != '0 && (br_q - 1'b1) <= BB'(in_g)) begin
                    od_next.status = aolih_pkg::ST_DROPPED;
                    state_next = S_DONE;
                end else if (br_q != '0 && sr_q != '0 && sr_q <= cnt_reg) begin
                    bw_en = 1'b1; bw_d = BB'(in_g) + 1'b1;
                    pos_next = sr_q; dn_next = 1'b1;
                    od_next.status = aolih_pkg::ST_DECREASED;
                    state_next = S_UPRD;
                end else if (cnt_reg >= SB'(HEAP_DEPTH)) begin
                    od_next.status = aolih_pkg::ST_CLEARED;
                    od_next.heap_full = 1'b1;
                    state_next = S_DONE;
                end else begin
                    bw_en = 1'b1; bw_d = BB'(in_g) + 1'b1;
                    cnt_next = cnt_reg + 1'b1; pos_next = cnt_reg + 1'b1;
                    dn_next = 1'b0;
                    od_next.status = aolih_pkg::ST_APPENDED;
                    state_next = S_UPRD;
                end
            end
            S_UPRD: begin
                // write the moving entry at its slot, read its parent
                hw_en = 1'b1;
                sw_en = 1'b1; sw_a = {cur_reg.y, cur_reg.x}; sw_d = pos_reg;
                oth_next = pos_reg >> 1;
                hr_a = pos_reg >> 1;
                if (pos_reg <= SB'(1)) begin
                    state_next = dn_reg ? S_DNRD : S_DONE;
                end else begin
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (key_of(cur_reg) < key_of(hr_q)) begin
                    hw_en = 1'b1; hw_d = hr_q;
                    sw_en = 1'b1; sw_a = {hr_q.y, hr_q.x}; sw_d = pos_reg;
                    pos_next = oth_reg;
                    state_next = S_UPRD;
                end else begin
                    state_next = dn_reg ? S_DNRD : S_DONE;
                end
            end
            S_POP1: begin
                od_next.status = aolih_pkg::ST_POPPED;
                od_next.out_x = 8'(hr_q.x); od_next.out_y = 8'(hr_q.y);
                od_next.out_cost_so_far = 16'(hr_q.g);
                od_next.out_cost_estimate = hr_q.h;
                sw_en = 1'b1; sw_a = {hr_q.y, hr_q.x}; sw_d = '0;
                hr_a = cnt_reg;
                cnt_next = cnt_reg - 1'b1;
                pos_next = SB'(1);
                state_next = (cnt_reg > SB'(1)) ? S_POP2 : S_DONE;
            end
            S_POP2: begin
                cur_next = hr_q;
                state_next = S_POSW;
            end
            S_POSW: begin
                hw_en = 1'b1;
                sw_en = 1'b1; sw_a = {cur_reg.y, cur_reg.x}; sw_d = pos_reg;
                state_next = S_DNRD;
            end
            S_DNRD: begin
                if ((32'(pos_reg) << 1) > 32'(cnt_reg)) begin
                    state_next = S_DONE;
                end else begin
                    hr_a = SB'(pos_reg << 1);
                    oth_next = SB'(pos_reg << 1);
                    state_next = S_DNR2;
                end
            end
            S_DNR2: begin
                lft_next = hr_q;
                hr_a = oth_reg + 1'b1;
                state_next = (oth_reg < cnt_reg) ? S_DNSEL : S_DNCMP;
            end
            S_DNSEL: begin
                if (key_of(hr_q) < key_of(lft_reg)) begin
                    lft_next = hr_q; oth_next = oth_reg + 1'b1;
                end
                state_next = S_DNCMP;
            end
            S_DNCMP: begin
                if (key_of(cur_reg) < key_of(lft_reg)) begin
                    state_next = S_DONE;
                end else begin
                    hw_en = 1'b1; hw_d = lft_reg;
                    sw_en = 1'b1; sw_a = {lft_reg.y, lft_reg.x}; sw_d = pos_reg;
                    pos_next = oth_reg;
                    state_next = S_POSW;
                end
            end
            S_DONE: begin
                if (!ov_reg || m_ready) begin
                    ov_next = 1'b1;
                    od_next.is_empty = (cnt_reg == '0);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR; clr_reg <= '0; cnt_reg <= '0; ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next; clr_reg <= clr_next; cnt_reg <= cnt_next;
            ov_reg <= ov_next;
        end
        pos_reg <= pos_next; oth_reg <= oth_next; cur_reg <= cur_next;
        lft_reg <= lft_next; dn_reg <= dn_next; cmd_reg <= cmd_next;
        od_reg <= od_next;
    end

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= SB'(HEAP_DEPTH)) else $error("entry count overflow");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result lost");
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POP1 |-> cnt_reg != '0) else $error("pop on empty");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open-list heap testbench
// Sends insert, pop and clear commands to the indexed min-heap, including a
// fill up to the full heap, and compares every result transfer against a
// model of the heap, the cell position table and the best-cost table kept
// inside a scoreboard.
// ----------------------------------------------------------------------------

// The scoreboard keeps its own copy of the heap and cell tables. Each input
// transfer is applied to that copy, and the expected result is queued.
class heap_scoreboard;
    localparam int DEPTH = 1024;

    aolih_pkg::out_item_t expected_q[$];
    int          errors;
    int          status_seen[8];
    logic [7:0]  ent_x[1:DEPTH];
    logic [7:0]  ent_y[1:DEPTH];
    logic [15:0] ent_g[1:DEPTH];
    logic [16:0] ent_h[1:DEPTH];
    int unsigned fill;
    int unsigned slot_of[65536];
    int unsigned best_of[65536];

    function new();
        errors = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        wipe_tables();
    endfunction

    function void wipe_tables();
        fill = 0;
        foreach (slot_of[i]) begin
            slot_of[i] = 0;
            best_of[i] = 0;
        end
    endfunction

    function int unsigned f_at(int unsigned s);
        return int'(ent_g[s]) + int'(ent_h[s]);
    endfunction

    function int unsigned cell_index(logic [7:0] x, logic [7:0] y);
        return {y, x};
    endfunction

    function void exchange(int unsigned a, int unsigned b);
        logic [7:0]  tx;
        logic [7:0]  ty;
        logic [15:0] tg;
        logic [16:0] th;
        tx = ent_x[a]; ty = ent_y[a]; tg = ent_g[a]; th = ent_h[a];
        ent_x[a] = ent_x[b]; ent_y[a] = ent_y[b];
        ent_g[a] = ent_g[b]; ent_h[a] = ent_h[b];
        ent_x[b] = tx; ent_y[b] = ty; ent_g[b] = tg; ent_h[b] = th;
        slot_of[cell_index(ent_x[a], ent_y[a])] = a;
        slot_of[cell_index(ent_x[b], ent_y[b])] = b;
    endfunction

    function void sift_up(int unsigned s);
        while (s > 1 && f_at(s) < f_at(s / 2)) begin
            exchange(s, s / 2);
            s = s / 2;
        end
    endfunction

    // Ties keep the left child, and a parent equal to its child still moves.
    function void sift_down(int unsigned s);
        int unsigned c;
        while (2 * s <= fill) begin
            c = 2 * s;
            if (c < fill && f_at(c + 1) < f_at(c)) c = c + 1;
            if (f_at(s) < f_at(c)) break;
            exchange(s, c);
            s = c;
        end
    endfunction

    function void note_command(aolih_pkg::in_item_t it);
        aolih_pkg::out_item_t r;
        int unsigned c;
        int unsigned best;
        int unsigned s;
        r = '0;
        r.status = aolih_pkg::ST_DROPPED;
        case (it.command)
            aolih_pkg::CMD_INSERT: begin
                c    = cell_index(it.cell_x, it.cell_y);
                best = best_of[c];
                s    = slot_of[c];
                if (best != 0 && best - 1 <= it.cost_so_far) begin
                    r.status = aolih_pkg::ST_DROPPED;
                end else if (best != 0 && s != 0 && s <= fill) begin
                    ent_g[s] = it.cost_so_far;
                    ent_h[s] = it.cost_estimate;
                    best_of[c] = it.cost_so_far + 1;
                    sift_up(s);
                    sift_down(slot_of[c]);
                    r.status = aolih_pkg::ST_DECREASED;
                end else if (fill >= DEPTH) begin
                    r.status    = aolih_pkg::ST_CLEARED;
                    r.heap_full = 1'b1;
                end else begin
                    fill = fill + 1;
                    ent_x[fill] = it.cell_x;
                    ent_y[fill] = it.cell_y;
                    ent_g[fill] = it.cost_so_far;
                    ent_h[fill] = it.cost_estimate;
                    slot_of[c]  = fill;
                    best_of[c]  = it.cost_so_far + 1;
                    sift_up(fill);
                    r.status = aolih_pkg::ST_APPENDED;
                end
            end
            aolih_pkg::CMD_POP: begin
                if (fill == 0) begin
                    r.status = aolih_pkg::ST_EMPTY;
                end else begin
                    r.out_x             = ent_x[1];
                    r.out_y             = ent_y[1];
                    r.out_cost_so_far   = ent_g[1];
                    r.out_cost_estimate = ent_h[1];
                    slot_of[cell_index(ent_x[1], ent_y[1])] = 0;
                    if (fill > 1) begin
                        ent_x[1] = ent_x[fill]; ent_y[1] = ent_y[fill];
                        ent_g[1] = ent_g[fill]; ent_h[1] = ent_h[fill];
                        slot_of[cell_index(ent_x[1], ent_y[1])] = 1;
                    end
                    fill = fill - 1;
                    if (fill > 1) sift_down(1);
                    r.status = aolih_pkg::ST_POPPED;
                end
            end
            aolih_pkg::CMD_CLEAR: begin
                wipe_tables();
                r.status = aolih_pkg::ST_CLEARED;
            end
            default: r.status = aolih_pkg::ST_DROPPED;
        endcase
        r.is_empty = (fill == 0);
        expected_q.push_back(r);
    endfunction

    function void check_result(aolih_pkg::out_item_t got);
        aolih_pkg::out_item_t exp_r;
        string     bad;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: result with nothing expected: %p", got);
            return;
        end
        exp_r = expected_q.pop_front();
        status_seen[got.status]++;
        bad = "";
        if (got.status !== exp_r.status) bad = {bad, " status"};
        if (got.heap_full !== exp_r.heap_full) bad = {bad, " heap_full"};
        if (got.out_x !== exp_r.out_x) bad = {bad, " out_x"};
        if (got.out_y !== exp_r.out_y) bad = {bad, " out_y"};
        if (got.out_cost_so_far !== exp_r.out_cost_so_far) bad = {bad, " out_cost_so_far"};
        if (got.out_cost_estimate !== exp_r.out_cost_estimate)
            bad = {bad, " out_cost_estimate"};
        if (got.is_empty !== exp_r.is_empty) bad = {bad, " is_empty"};
        if (bad != "") begin
            errors++;
            if (errors <= 10) begin
                $display("ERROR: mismatch in%s", bad);
                $display("  expected %p", exp_r);
                $display("  actual   %p", got);
            end
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module testbench;
    localparam int HEAP_DEPTH  = 1024;
    localparam int CYCLE_LIMIT = 3000000;
    // Command code that the block does not act on; it answers with a drop.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    aolih_pkg::in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    aolih_pkg::out_item_t m_data;

    heap_scoreboard sb = new();

    // Idle percentages of the two sides, changed phase by phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int clears_left = 2;

    astar_open_list_indexed_heap #(
        .X_BITS(8), .Y_BITS(8), .HEAP_DEPTH(HEAP_DEPTH), .COST_BITS(16)
    ) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // Watchdog: the slowest legal run, with every clearing sweep of the cell
    // tables, stays well below this count.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver decides its stall at each falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Results are sampled at the rising edge, before the block's own updates.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Presents one command and holds it until the transfer. Valid stays high
    // afterwards unless the next call decides to idle first.
    task automatic send_item(aolih_pkg::in_item_t it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(it);
        @(negedge aclk);
    endtask

    task automatic send_cmd(logic [1:0] cmd, logic [7:0] x, logic [7:0] y,
                            logic [15:0] g, logic [16:0] h);
        aolih_pkg::in_item_t it;
        it.command       = cmd;
        it.cell_x        = x;
        it.cell_y        = y;
        it.cost_so_far   = g;
        it.cost_estimate = h;
        send_item(it);
    endtask

    // Holds the sender back until every expected result has arrived.
    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // Mostly inserts and pops on a small patch of the grid, so that cells
    // come back and keys are decreased or dropped; now and then a cell from
    // anywhere, full-width costs, the unused command or a clear.
    function automatic aolih_pkg::in_item_t random_item();
        aolih_pkg::in_item_t it;
        int       r;
        r = $urandom_range(99);
        it.cost_so_far   = ($urandom_range(9) < 7) ? 16'($urandom_range(1000))
                                                    : 16'($urandom_range(65535));
        it.cost_estimate = ($urandom_range(1) == 0) ? 17'($urandom_range(2000))
                                                    : 17'($urandom_range(131071));
        if ($urandom_range(9) < 8) begin
            it.cell_x = 8'($urandom_range(7));
            it.cell_y = 8'($urandom_range(7));
        end else begin
            it.cell_x = 8'($urandom_range(255));
            it.cell_y = 8'($urandom_range(255));
        end
        if (r < 55)      it.command = aolih_pkg::CMD_INSERT;
        else if (r < 95) it.command = aolih_pkg::CMD_POP;
        else if (r < 99) it.command = CMD_UNUSED;
        else if (clears_left > 0) begin
            it.command  = aolih_pkg::CMD_CLEAR;
            clears_left = clears_left - 1;
        end else it.command = aolih_pkg::CMD_POP;
        return it;
    endfunction

    task automatic random_phase(int n, int send_pct, int recv_pct, bit pause_once);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < n; i++) begin
            if (pause_once && i == n / 2) drain();
            send_item(random_item());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: an empty pop, the field extremes, drops, a key
        // decrease that raises f and must sift down, equal keys, a popped
        // cell coming back, the unused command and a clear.
        send_cmd(aolih_pkg::CMD_POP,    8'd0,   8'd0,   16'd0,     17'd0);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd0,   8'd0,   16'd0,     17'd0);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd255, 8'd255, 16'd65535, 17'd131071);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd255, 8'd0,   16'd65534, 17'd130050);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd0,   8'd255, 16'd100,   17'd50);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd0,   8'd255, 16'd100,   17'd0);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd0,   8'd255, 16'd200,   17'd0);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd0,   8'd255, 16'd99,    17'd131071);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd3,   8'd4,   16'd10,    17'd20);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd4,   8'd3,   16'd20,    17'd10);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd5,   8'd5,   16'd15,    17'd15);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd0,   8'd0,   16'd0,     17'd5);
        send_cmd(CMD_UNUSED,            8'd170, 8'd85,  16'd43690, 17'd87381);
        for (int i = 0; i < 4; i++)
            send_cmd(aolih_pkg::CMD_POP, 8'd85, 8'd170, 16'd21845, 17'd43690);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd4,   8'd3,   16'd19,    17'd1);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd3,   8'd4,   16'd11,    17'd1);
        for (int i = 0; i < 5; i++)
            send_cmd(aolih_pkg::CMD_POP, 8'd0, 8'd0, 16'd0, 17'd0);
        send_cmd(aolih_pkg::CMD_CLEAR,  8'd0,   8'd0,   16'd0,     17'd0);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd0,   8'd0,   16'd7,     17'd7);

        // Fill the heap to the last slot, then one more cell is refused while
        // a cell already present can still have its key decreased.
        send_cmd(aolih_pkg::CMD_CLEAR, 8'd0, 8'd0, 16'd0, 17'd0);
        for (int i = 0; i < HEAP_DEPTH; i++)
            send_cmd(aolih_pkg::CMD_INSERT, 8'(i), 8'(i >> 8) + 8'd16,
                     16'($urandom_range(1000)) + 16'd10, 17'($urandom_range(131071)));
        send_cmd(aolih_pkg::CMD_INSERT, 8'd200, 8'd200, 16'd1, 17'd1);
        send_cmd(aolih_pkg::CMD_INSERT, 8'd7,   8'd16,  16'd0, 17'd0);
        for (int i = 0; i < 20; i++)
            send_cmd(aolih_pkg::CMD_POP, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     16'($urandom_range(65535)), 17'($urandom_range(131071)));
        send_cmd(aolih_pkg::CMD_CLEAR, 8'd0, 8'd0, 16'd0, 17'd0);

        // Random part in four idling phases; the sender waits once for all
        // results in the slow-sender phase.
        random_phase(200, 0,  0,  1'b0);
        random_phase(200, 86, 0,  1'b1);
        random_phase(200, 0,  86, 1'b0);
        random_phase(200, 25, 25, 1'b0);

        drain();
        repeat (100) @(posedge aclk);

        $display("Covered directed extremes, a full heap and 800 random commands.");
        $display("Results by status: appended %0d, dropped %0d, decreased %0d,",
                 sb.status_seen[aolih_pkg::ST_APPENDED],
                 sb.status_seen[aolih_pkg::ST_DROPPED],
                 sb.status_seen[aolih_pkg::ST_DECREASED]);
        $display("  popped %0d, empty %0d, cleared or full %0d",
                 sb.status_seen[aolih_pkg::ST_POPPED],
                 sb.status_seen[aolih_pkg::ST_EMPTY],
                 sb.status_seen[aolih_pkg::ST_CLEARED]);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* astar_open_list_indexed_heap.f */
sv/aolih_pkg.sv
sv/astar_open_list_indexed_heap.sv
tb/testbench.sv
